/* hdl/rle_run_tokenizer_defines.svh */
// Assertion macros shared by the run tokenizer RTL.
// Uses the clk and rst_n names of the module that includes it; no other dependencies.
`ifndef RLE_RUN_TOKENIZER_DEFINES_SVH
`define RLE_RUN_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rle_tok_pkg.sv */
// Types, codes and constants of the run tokenizer.
// No dependencies; imported by every module of the block.
package rle_tok_pkg;

    // Configuration port.
    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 8;

    localparam logic [CfgAddrW-1:0] CFG_MIN_REPEAT = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_MAX_REPEAT = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_MIN_COPY   = 2'd2;
    localparam logic [CfgAddrW-1:0] CFG_MAX_COPY   = 2'd3;

    // Token kinds on the output channel.
    localparam logic [1:0] TOK_REPEAT = 2'd0;
    localparam logic [1:0] TOK_COPY   = 2'd1;
    localparam logic [1:0] TOK_ERROR  = 2'd2;

    // One byte can produce at most two tokens.
    localparam logic [1:0] MaxTokens = 2'd2;

    // Token queue; the depth must be a power of two so that pointers wrap.
    localparam int TokFifoDepth = 4;
    localparam int TokPtrW      = $clog2(TokFifoDepth);
    localparam int TokCntW      = $clog2(TokFifoDepth + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [1:0] token_kind;
        logic [7:0] run_length;
        logic [7:0] repeat_value;
        logic       stream_end;
    } token_t;

    // Registers hold the effective value: a written zero is kept as one.
    typedef struct packed {
        logic [7:0] min_repeat;
        logic [7:0] max_repeat;
        logic [7:0] min_copy;
        logic [7:0] max_copy;
    } cfg_t;

    localparam cfg_t CfgReset = '{
        min_repeat: 8'd2,
        max_repeat: 8'd128,
        min_copy:   8'd1,
        max_copy:   8'd128
    };

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_REP,
        RUN_CPY
    } run_kind_t;

    // Open run and the error flag that drops bytes until the end of the stream.
    typedef struct packed {
        run_kind_t  kind;
        logic [7:0] count;
        logic [7:0] value;
        logic       err;
    } run_state_t;

    localparam run_state_t RunReset = '{
        kind:  RUN_IDLE,
        count: 8'd0,
        value: 8'd0,
        err:   1'b0
    };

    // Up to two tokens made by one byte, in stream order.
    typedef struct packed {
        logic [1:0] num;
        token_t     first;
        token_t     second;
    } tok_pair_t;

endpackage

/* hdl/rle_run_tokenizer.sv */
// Top level of the greedy repeat/copy run tokenizer.
// Depends on rle_tok_pkg, rle_tok_step, rle_tok_fifo and the assertion macro header.
//
// Usage:
//   Bytes enter on the byte channel (byte_valid/byte_ready/byte_data); last_byte
//   marks the final byte of a stream and flushes the open run. Tokens leave on the
//   tok channel (tok_valid/tok_ready/tok_data); the final token of a stream has
//   stream_end set. After an error token, bytes give no tokens until the last
//   byte of the stream.
//   The configuration port writes one 8-bit register per cycle with cfg_we;
//   cfg_addr selects min_repeat, max_repeat, min_copy or max_copy. A written zero
//   acts as one. Write only while no token is in flight.
//   A transferred byte waits in the input register until the token queue has
//   room; it is then evaluated, and its tokens are offered from the queue.
//   Throughput: one byte per cycle while the receiver keeps up. A byte makes at
//   most two tokens and the output moves one token per cycle, so the four-entry
//   token queue sets the pace when two-token bytes come back to back.
//   Reset clears the open run, the token queue and the error flag, and loads the
//   register defaults (2, 128, 1, 128).
//   When the receiver stalls, tokens collect in the queue; the byte channel keeps
//   taking bytes until the queue has no room for two more tokens.
`include "rle_run_tokenizer_defines.svh"

module rle_run_tokenizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_ready,
    input  rle_tok_pkg::byte_item_t             byte_data,
    output logic                                tok_valid,
    input  logic                                tok_ready,
    output rle_tok_pkg::token_t                 tok_data,
    input  logic                                cfg_we,
    input  logic [rle_tok_pkg::CfgAddrW-1:0]    cfg_addr,
    input  logic [rle_tok_pkg::CfgDataW-1:0]    cfg_wdata
);
    import rle_tok_pkg::*;

    cfg_t       cfg_reg;
    logic [7:0] cfg_eff;
    logic       in_vld_reg;
    byte_item_t in_data_reg;
    run_state_t run_reg;
    run_state_t run_next;
    tok_pair_t  step_tokens;
    tok_pair_t  fifo_push;
    logic       fifo_room;
    logic       proc_go;

    // Configuration registers; a zero is stored as one.
    assign cfg_eff = (cfg_wdata == '0) ? 8'd1 : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CfgReset;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MIN_REPEAT: cfg_reg.min_repeat <= cfg_eff;
                CFG_MAX_REPEAT: cfg_reg.max_repeat <= cfg_eff;
                CFG_MIN_COPY:   cfg_reg.min_copy   <= cfg_eff;
                CFG_MAX_COPY:   cfg_reg.max_copy   <= cfg_eff;
                default:
                begin
                end
            endcase
        end
    end

    // Input register; it refills in the same cycle that its byte is evaluated.
    assign proc_go    = in_vld_reg && fifo_room;
    assign byte_ready = !in_vld_reg || proc_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            in_vld_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_data_reg <= byte_data;
        end
    end

    // Tokenizer step against the open run.
    rle_tok_step u_step (
        .cfg        (cfg_reg),
        .state      (run_reg),
        .item       (in_data_reg),
        .state_next (run_next),
        .tokens     (step_tokens)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= RunReset;
        end
        else if (proc_go)
        begin
            run_reg <= run_next;
        end
    end

    // Tokens of an evaluated byte go into the queue.
    always_comb
    begin
        fifo_push = step_tokens;
        if (!proc_go)
        begin
            fifo_push.num = 2'd0;
        end
    end

    rle_tok_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fifo_push),
        .room       (fifo_room),
        .head_valid (tok_valid),
        .head_ready (tok_ready),
        .head       (tok_data)
    );

    // Checks on run state and token contents.
    `RLE_ASSERT_IMP(a_err_idle, run_reg.err, run_reg.kind == RUN_IDLE && run_reg.count == 8'd0, "error state with an open run")
    `RLE_ASSERT_NXT(a_last_rearms, proc_go && in_data_reg.last_byte, run_reg.kind == RUN_IDLE && !run_reg.err, "last byte did not close the stream")
    `RLE_ASSERT_IMP(a_err_token, tok_valid && tok_data.token_kind == TOK_ERROR, tok_data.run_length == 8'd0 && tok_data.stream_end, "malformed error token")
    `RLE_ASSERT_IMP(a_copy_token, tok_valid && tok_data.token_kind == TOK_COPY, tok_data.run_length != 8'd0 && tok_data.repeat_value == 8'd0, "malformed copy token")

endmodule

/* hdl/rle_tok_fifo.sv */
// Small token queue that takes up to two tokens per cycle and gives one while head_ready is high.
// Depends on rle_tok_pkg for the token types and the queue depth.
module rle_tok_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rle_tok_pkg::tok_pair_t push,
    output logic                   room,
    output logic                   head_valid,
    input  logic                   head_ready,
    output rle_tok_pkg::token_t    head
);
    import rle_tok_pkg::*;

    token_t               mem_reg [TokFifoDepth];
    logic [TokPtrW-1:0]   wr_ptr_reg;
    logic [TokPtrW-1:0]   wr_ptr_next;
    logic [TokPtrW-1:0]   wr_ptr_p1;
    logic [TokPtrW-1:0]   rd_ptr_reg;
    logic [TokPtrW-1:0]   rd_ptr_next;
    logic [TokCntW-1:0]   count_reg;
    logic [TokCntW-1:0]   count_next;
    logic                 pop;

    // Handshake toward the output and toward the tokenizer step.
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    assign room       = (count_reg <= TokCntW'(TokFifoDepth - int'(MaxTokens)));

    // Pointer and fill count updates.
    assign wr_ptr_p1   = TokPtrW'(wr_ptr_reg + 1'b1);
    assign wr_ptr_next = TokPtrW'(wr_ptr_reg + TokPtrW'(push.num));
    assign rd_ptr_next = TokPtrW'(rd_ptr_reg + TokPtrW'(pop));
    assign count_next  = TokCntW'(count_reg + TokCntW'(push.num) - TokCntW'(pop));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage; the second token goes into the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == MaxTokens)
        begin
            mem_reg[wr_ptr_p1] <= push.second;
        end
    end

endmodule

/* hdl/rle_tok_step.sv */
// Combinational tokenizer step: one byte against the open run gives the next
// run state and up to two tokens. Depends on rle_tok_pkg.
module rle_tok_step (
    input  rle_tok_pkg::cfg_t       cfg,
    input  rle_tok_pkg::run_state_t state,
    input  rle_tok_pkg::byte_item_t item,
    output rle_tok_pkg::run_state_t state_next,
    output rle_tok_pkg::tok_pair_t  tokens
);
    import rle_tok_pkg::*;

    typedef struct packed {
        run_state_t st;
        tok_pair_t  tl;
    } work_t;

    function automatic token_t make_tok(logic [1:0] kind, logic [7:0] len, logic [7:0] val);
        token_t t;
        t.token_kind   = kind;
        t.run_length   = len;
        t.repeat_value = val;
        t.stream_end   = 1'b0;
        return t;
    endfunction

    // Append a token; anything past the second is dropped.
    function automatic work_t push_tok(work_t w, token_t t);
        work_t r;
        r = w;
        if (w.tl.num == 2'd0)
        begin
            r.tl.first = t;
        end
        else if (w.tl.num == 2'd1)
        begin
            r.tl.second = t;
        end
        if (w.tl.num < MaxTokens)
        begin
            r.tl.num = w.tl.num + 2'd1;
        end
        return r;
    endfunction

    function automatic work_t go_idle(work_t w);
        work_t r;
        r = w;
        r.st.kind  = RUN_IDLE;
        r.st.count = 8'd0;
        r.st.value = 8'd0;
        return r;
    endfunction

    // An error token closes the stream and drops bytes until its last byte.
    function automatic work_t fail(work_t w);
        work_t  r;
        token_t t;
        t            = make_tok(TOK_ERROR, 8'd0, 8'd0);
        t.stream_end = 1'b1;
        r            = push_tok(w, t);
        r.st.err     = 1'b1;
        r            = go_idle(r);
        return r;
    endfunction

    function automatic work_t emit_copy(work_t w, logic [7:0] k, cfg_t c);
        work_t r;
        if (k != 8'd0 && k >= c.min_copy)
        begin
            r = push_tok(w, make_tok(TOK_COPY, k, 8'd0));
        end
        else
        begin
            r = fail(w);
        end
        return r;
    endfunction

    // A byte with no run open starts one, or is a one-byte repeat token if max_repeat and min_repeat are one.
    function automatic work_t feed_idle(work_t w, logic [7:0] b, cfg_t c);
        work_t r;
        r = w;
        if (c.max_repeat > 8'd1)
        begin
            r.st.kind  = RUN_REP;
            r.st.count = 8'd1;
            r.st.value = b;
        end
        else if (c.min_repeat <= 8'd1)
        begin
            r = push_tok(r, make_tok(TOK_REPEAT, 8'd1, b));
            r = go_idle(r);
        end
        else
        begin
            r.st.kind  = RUN_CPY;
            r.st.count = 8'd1;
            r.st.value = b;
        end
        return r;
    endfunction

    // Flush of the open run on the last byte of the stream.
    function automatic work_t finish(work_t w, cfg_t c);
        work_t r;
        r = w;
        if (!w.st.err)
        begin
            case (w.st.kind)
                RUN_REP:
                begin
                    if (w.st.count >= c.min_repeat)
                    begin
                        r = push_tok(r, make_tok(TOK_REPEAT, w.st.count, w.st.value));
                    end
                    else if (w.st.count >= 8'd2)
                    begin
                        r = fail(r);
                    end
                    else
                    begin
                        r = emit_copy(r, 8'd1, c);
                    end
                end
                RUN_CPY:
                begin
                    r = emit_copy(r, w.st.count, c);
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    always_comb
    begin
        work_t      w;
        logic [7:0] b;
        logic [7:0] v;
        logic [7:0] cnt_inc;
        logic [7:0] cnt_dec;

        b       = item.data_byte;
        v       = state.value;
        cnt_inc = state.count + 8'd1;
        cnt_dec = state.count - 8'd1;
        w.st    = state;
        w.tl    = '0;

        if (state.err)
        begin
            // Bytes are dropped; the last byte of the stream rearms the block.
            if (item.last_byte)
            begin
                w.st = RunReset;
            end
        end
        else
        begin
            case (state.kind)
                RUN_IDLE:
                begin
                    w = feed_idle(w, b, cfg);
                end
                RUN_REP:
                begin
                    if (b == v)
                    begin
                        // The run grows; at its cap it is closed, or gives an error below min_repeat.
                        w.st.count = cnt_inc;
                        if (cnt_inc >= cfg.max_repeat)
                        begin
                            if (cnt_inc >= cfg.min_repeat)
                            begin
                                w = push_tok(w, make_tok(TOK_REPEAT, cnt_inc, v));
                                w = go_idle(w);
                            end
                            else
                            begin
                                w = fail(w);
                            end
                        end
                    end
                    else if (state.count >= cfg.min_repeat)
                    begin
                        w = push_tok(w, make_tok(TOK_REPEAT, state.count, v));
                        w = go_idle(w);
                        w = feed_idle(w, b, cfg);
                    end
                    else if (state.count >= 8'd2)
                    begin
                        w = fail(w);
                    end
                    else if (cfg.max_copy > 8'd1)
                    begin
                        // A single byte turns into a copy run that takes this byte.
                        w.st.kind  = RUN_CPY;
                        w.st.count = 8'd2;
                        w.st.value = b;
                    end
                    else
                    begin
                        w = emit_copy(w, 8'd1, cfg);
                        if (!w.st.err)
                        begin
                            w = go_idle(w);
                            w = feed_idle(w, b, cfg);
                        end
                    end
                end
                RUN_CPY:
                begin
                    if (b == v)
                    begin
                        // An equal pair ends the copy run before its first byte.
                        w = emit_copy(w, cnt_dec, cfg);
                        if (!w.st.err)
                        begin
                            w = go_idle(w);
                            if (cfg.max_repeat > 8'd1)
                            begin
                                if (cfg.max_repeat <= 8'd2)
                                begin
                                    if (cfg.min_repeat <= 8'd2)
                                    begin
                                        w = push_tok(w, make_tok(TOK_REPEAT, 8'd2, v));
                                        w = go_idle(w);
                                    end
                                    else
                                    begin
                                        w = fail(w);
                                    end
                                end
                                else
                                begin
                                    w.st.kind  = RUN_REP;
                                    w.st.count = 8'd2;
                                    w.st.value = v;
                                end
                            end
                            else if (cfg.min_repeat <= 8'd1)
                            begin
                                w = push_tok(w, make_tok(TOK_REPEAT, 8'd1, v));
                                w = push_tok(w, make_tok(TOK_REPEAT, 8'd1, v));
                            end
                            else
                            begin
                                w = fail(w);
                            end
                        end
                    end
                    else if (state.count < cfg.max_copy)
                    begin
                        w.st.count = cnt_inc;
                        w.st.value = b;
                    end
                    else
                    begin
                        w = emit_copy(w, state.count, cfg);
                        if (!w.st.err)
                        begin
                            w = go_idle(w);
                            w = feed_idle(w, b, cfg);
                        end
                    end
                end
                default:
                begin
                    w = go_idle(w);
                end
            endcase

            // End of stream: flush and mark the final token.
            if (item.last_byte)
            begin
                w = finish(w, cfg);
                if (w.tl.num == 2'd1)
                begin
                    w.tl.first.stream_end = 1'b1;
                end
                else if (w.tl.num == MaxTokens)
                begin
                    w.tl.second.stream_end = 1'b1;
                end
                w.st = RunReset;
            end
        end

        state_next = w.st;
        tokens     = w.tl;
    end

endmodule

/* tb/sv/rle_run_tokenizer_test.sv */
// Self-checking testbench for the greedy repeat/copy run tokenizer.
// Depends on rle_tok_pkg and rle_run_tokenizer; a built-in run predictor supplies
// the expected tokens, and directed plus random byte streams drive the block.
`timescale 1ns / 1ps

module rle_run_tokenizer_test;

    import rle_tok_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    // Clock, reset and block ports.
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_ready;
    byte_item_t          byte_data  = '0;
    logic                tok_valid;
    logic                tok_ready  = 1'b0;
    token_t              tok_data;
    logic                cfg_we     = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr   = '0;
    logic [CfgDataW-1:0] cfg_wdata  = '0;

    // Predictor state: register copy, open run and the drop flag after an error.
    cfg_t        regs       = CfgReset;
    run_kind_t   open_kind  = RUN_IDLE;
    logic [7:0]  open_count = 8'd0;
    logic [7:0]  open_value = 8'd0;
    bit          dropping   = 1'b0;

    // Tokens made by the byte being predicted, and tokens still to arrive.
    token_t      step_tokens [2];
    int unsigned step_count;
    token_t      tokens_due [$];
    token_t      arrived_want;

    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_left     = 0;
    int unsigned sink_hold_req = 0;
    bit          calm          = 1'b0;

    rle_run_tokenizer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_data   (tok_data),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    // Free-running clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cycle budget for the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run predictor
    // ------------------------------------------------------------------

    // A register that holds zero behaves as one.
    function automatic int unsigned at_least_one(logic [7:0] r);
        return (r == 8'd0) ? 32'd1 : {24'd0, r};
    endfunction

    function automatic void add_token(logic [1:0] kind, int unsigned len,
                                      logic [7:0] val, bit last);
        if (step_count >= MaxTokens)
            return;
        step_tokens[step_count].token_kind   = kind;
        step_tokens[step_count].run_length   = len[7:0];
        step_tokens[step_count].repeat_value = val;
        step_tokens[step_count].stream_end   = last;
        step_count++;
    endfunction

    function automatic void clear_open_run();
        open_kind  = RUN_IDLE;
        open_count = 8'd0;
        open_value = 8'd0;
    endfunction

    // An error token ends the stream; later bytes are dropped until the last one.
    function automatic void raise_error();
        add_token(TOK_ERROR, 0, 8'd0, 1'b1);
        dropping = 1'b1;
        clear_open_run();
    endfunction

    function automatic void close_copy_run(int unsigned k);
        if (k >= 1 && k >= at_least_one(regs.min_copy))
            add_token(TOK_COPY, k, 8'd0, 1'b0);
        else
            raise_error();
    endfunction

    // Feeds one byte to the run state. A byte that closes a run is fed again to
    // the fresh run, so pending bytes are worked off from a small list.
    function automatic void tokenize_byte(logic [7:0] b);
        logic [7:0]  work [$];
        logic [7:0]  x;
        logic [7:0]  v;
        int unsigned c;
        int unsigned n;
        work.push_back(b);
        while (work.size() != 0)
        begin
            x = work.pop_front();
            if (dropping)
                break;
            if (open_kind == RUN_IDLE)
            begin
                if (at_least_one(regs.max_repeat) > 1)
                begin
                    open_kind  = RUN_REP;
                    open_count = 8'd1;
                    open_value = x;
                end
                else if (at_least_one(regs.min_repeat) <= 1)
                    add_token(TOK_REPEAT, 1, x, 1'b0);
                else
                begin
                    open_kind  = RUN_CPY;
                    open_count = 8'd1;
                    open_value = x;
                end
            end
            else if (open_kind == RUN_REP)
            begin
                v = open_value;
                c = 32'(open_count);
                if (x == v)
                begin
                    c++;
                    open_count = c[7:0];
                    if (c >= at_least_one(regs.max_repeat))
                    begin
                        if (c >= at_least_one(regs.min_repeat))
                        begin
                            add_token(TOK_REPEAT, c, v, 1'b0);
                            clear_open_run();
                        end
                        else
                            raise_error();
                    end
                end
                else if (c >= at_least_one(regs.min_repeat))
                begin
                    add_token(TOK_REPEAT, c, v, 1'b0);
                    clear_open_run();
                    work.push_back(x);
                end
                else if (c >= 2)
                    raise_error();
                else
                begin
                    // A lone byte turns into the start of a copy run.
                    open_kind  = RUN_CPY;
                    open_count = 8'd1;
                    work.push_back(x);
                end
            end
            else
            begin
                v = open_value;
                n = 32'(open_count);
                if (x == v)
                begin
                    // An equal pair ends the copy run before its first byte.
                    close_copy_run(n - 1);
                    clear_open_run();
                    work.push_back(v);
                    work.push_back(x);
                end
                else if (n < at_least_one(regs.max_copy))
                begin
                    n++;
                    open_count = n[7:0];
                    open_value = x;
                end
                else
                begin
                    close_copy_run(n);
                    clear_open_run();
                    work.push_back(x);
                end
            end
        end
    endfunction

    // Closes whatever run is open at the end of a stream.
    function automatic void flush_open_run();
        int unsigned c;
        if (dropping)
            return;
        if (open_kind == RUN_REP)
        begin
            c = 32'(open_count);
            if (c >= at_least_one(regs.min_repeat))
                add_token(TOK_REPEAT, c, open_value, 1'b0);
            else if (c >= 2)
                raise_error();
            else
                close_copy_run(1);
        end
        else if (open_kind == RUN_CPY)
            close_copy_run(32'(open_count));
        clear_open_run();
    endfunction

    // Works out the tokens of one transferred byte and queues them.
    function automatic void predict_tokens(byte_item_t item);
        int unsigned i;
        step_count = 0;
        if (dropping)
        begin
            if (item.last_byte)
            begin
                dropping = 1'b0;
                clear_open_run();
            end
            return;
        end
        tokenize_byte(item.data_byte);
        if (item.last_byte)
        begin
            flush_open_run();
            if (step_count > 0)
                step_tokens[step_count - 1].stream_end = 1'b1;
            clear_open_run();
            dropping = 1'b0;
        end
        for (i = 0; i < step_count; i++)
            tokens_due.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Token receiver and checker
    // ------------------------------------------------------------------

    // Ready is dropped at random, held low for a requested stretch, or kept high.
    always @(posedge clk)
    begin
        if (sink_hold_req != 0)
        begin
            hold_left     = sink_hold_req;
            sink_hold_req = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            tok_ready <= 1'b0;
        end
        else if (calm)
            tok_ready <= 1'b1;
        else
            tok_ready <= ($urandom_range(99) >= 38);
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Each token transfer is matched against the oldest expected token.
    always @(posedge clk)
    begin
        if (rst_n && tok_valid && tok_ready)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("token of kind %0d arrived with none expected", tok_data.token_kind);
                fail_count++;
            end
            else
            begin
                arrived_want = tokens_due.pop_front();
                check_field("token_kind", 8'(arrived_want.token_kind),
                            8'(tok_data.token_kind));
                check_field("run_length", arrived_want.run_length, tok_data.run_length);
                check_field("repeat_value", arrived_want.repeat_value,
                            tok_data.repeat_value);
                check_field("stream_end", 8'(arrived_want.stream_end),
                            8'(tok_data.stream_end));
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte sender and configuration
    // ------------------------------------------------------------------

    // Offers one byte, at random after a gap unless calm is set, and waits for its transfer.
    task automatic send_byte(logic [7:0] d, logic l);
        byte_item_t item;
        item.data_byte = d;
        item.last_byte = l;
        if (!calm && $urandom_range(99) < 38)
        begin
            byte_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 38);
        end
        byte_valid <= 1'b1;
        byte_data  <= item;
        do
            @(posedge clk);
        while (!byte_ready);
        predict_tokens(item);
    endtask

    // Stops sending until every expected token has arrived, then lets the block settle.
    task automatic wait_drained(int unsigned settle);
        byte_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        case (addr)
            CFG_MIN_REPEAT: regs.min_repeat = value;
            CFG_MAX_REPEAT: regs.max_repeat = value;
            CFG_MIN_COPY:   regs.min_copy   = value;
            CFG_MAX_COPY:   regs.max_copy   = value;
            default: ;
        endcase
    endtask

    // Writes all four registers; call only while the block is idle.
    task automatic set_config(cfg_t c);
        wait_drained(4);
        write_reg(CFG_MIN_REPEAT, c.min_repeat);
        write_reg(CFG_MAX_REPEAT, c.max_repeat);
        write_reg(CFG_MIN_COPY, c.min_copy);
        write_reg(CFG_MAX_COPY, c.max_copy);
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t make_cfg(logic [7:0] min_rep, logic [7:0] max_rep,
                                      logic [7:0] min_cpy, logic [7:0] max_cpy);
        cfg_t c;
        c.min_repeat = min_rep;
        c.max_repeat = max_rep;
        c.min_copy   = min_cpy;
        c.max_copy   = max_cpy;
        return c;
    endfunction

    // Half the values come from a tiny set so that neighboring runs often match.
    function automatic logic [7:0] pick_value();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(3));
    endfunction

    // One stream built from runs of equal bytes; the final byte carries last_byte.
    task automatic send_stream(int unsigned len, bit long_runs);
        int unsigned left;
        int unsigned run;
        logic [7:0]  v;
        left = len;
        while (left != 0)
        begin
            v = pick_value();
            if (long_runs && $urandom_range(3) == 0)
                run = $urandom_range(100, 140);
            else
                run = $urandom_range(1, 5);
            if (run > left)
                run = left;
            repeat (run)
            begin
                send_byte(v, left == 1);
                left--;
            end
        end
    endtask

    task automatic run_streams(int unsigned nbytes, bit long_runs);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < nbytes)
        begin
            len = long_runs ? $urandom_range(1, 300) : $urandom_range(1, 40);
            send_stream(len, long_runs);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Single bytes at both value extremes, a plain repeat, and copy around repeat.
    task automatic test_directed_basic();
        set_config(CfgReset);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    // Error cases, bytes dropped after an error, and register extremes.
    task automatic test_directed_limits();
        // A repeat of two below min_repeat is an error.
        set_config(make_cfg(8'd3, 8'd128, 8'd1, 8'd128));
        send_byte(8'h07, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h08, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b1);
        // Every byte becomes a one-byte repeat token.
        set_config(make_cfg(8'd1, 8'd1, 8'd1, 8'd1));
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        // Repeats cannot form, so an equal pair closes the copy run and gives an error.
        set_config(make_cfg(8'd2, 8'd1, 8'd1, 8'd128));
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h02, 1'b1);
        // Zero registers behave as one.
        set_config(make_cfg(8'd0, 8'd0, 8'd0, 8'd0));
        send_byte(8'h33, 1'b1);
        // A copy run shorter than min_copy is an error.
        set_config(make_cfg(8'd2, 8'd128, 8'd128, 8'd128));
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
    endtask

    task automatic test_random_default();
        set_config(CfgReset);
        run_streams(300, 1'b0);
        run_streams(250, 1'b1);
    endtask

    // Random streams under a spread of settings, the extremes among them.
    task automatic test_random_settings();
        cfg_t        settings [10];
        int unsigned i;
        settings[0] = make_cfg(8'd1, 8'd1, 8'd1, 8'd1);
        settings[1] = make_cfg(8'd128, 8'd128, 8'd128, 8'd128);
        settings[2] = make_cfg(8'd2, 8'd128, 8'd1, 8'd128);
        settings[3] = make_cfg(8'd1, 8'd128, 8'd1, 8'd1);
        settings[4] = make_cfg(8'd3, 8'd4, 8'd1, 8'd3);
        settings[5] = make_cfg(8'd2, 8'd2, 8'd2, 8'd2);
        settings[6] = make_cfg(8'd1, 8'd2, 8'd1, 8'd2);
        for (i = 7; i < 10; i++)
            settings[i] = make_cfg(8'($urandom_range(1, 4)), 8'($urandom_range(1, 16)),
                                   8'($urandom_range(1, 3)), 8'($urandom_range(1, 16)));
        for (i = 0; i < 10; i++)
        begin
            set_config(settings[i]);
            run_streams(100, settings[i].min_repeat > 8 || settings[i].min_copy > 8);
        end
    endtask

    // Both sides keep up for a long stretch.
    task automatic test_calm_stretch();
        set_config(make_cfg(8'd2, 8'd16, 8'd1, 8'd16));
        calm = 1'b1;
        run_streams(250, 1'b0);
        calm = 1'b0;
    endtask

    // The receiver holds off while short runs keep the token queue filling.
    task automatic test_backpressure();
        set_config(CfgReset);
        calm          = 1'b1;
        sink_hold_req = 300;
        run_streams(150, 1'b0);
        calm = 1'b0;
    endtask

    // The sender pauses mid-stream until every expected token is out.
    task automatic test_sender_pause();
        set_config(make_cfg(8'd2, 8'd8, 8'd1, 8'd8));
        repeat (20)
        begin
            repeat (5) send_byte(pick_value(), 1'b0);
            wait_drained(0);
            repeat (2) send_byte(pick_value(), 1'b0);
            send_byte(pick_value(), 1'b1);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_basic();
        test_directed_limits();
        test_random_default();
        test_random_settings();
        test_calm_stretch();
        test_backpressure();
        test_sender_pause();

        wait_drained(8);
        if (fail_count == 0 && tokens_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
